// ===== rtl/acsr_pkg.sv =====
// acsr_pkg: shared types and constants of the contrast stretch recolour block.
// No dependencies; imported by every module of the block.
package acsr_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};
	localparam logic [CHANNEL_BITS-1:0] CHAN_HALF = CHAN_MAX >> 1;

	// serial units retire one bit per cycle
	localparam int STEPS  = CHANNEL_BITS;
	localparam int CNT_W  = $clog2(STEPS);
	localparam int PROD_W = 2 * CHANNEL_BITS;
	localparam int NUM_W  = 2 * CHANNEL_BITS + 1;
	localparam int DEN_W  = CHANNEL_BITS + 1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE  = 2'd2;

	localparam logic CMD_MEASURE = 1'b0;
	localparam logic CMD_RECOLOR = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic       frame_start;
		logic [7:0] pix_red;
		logic [7:0] pix_green;
		logic [7:0] pix_blue;
		logic [7:0] pix_alpha;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} result_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIV1 = 6'b000100,
		ST_PREP = 6'b001000,
		ST_DIV2 = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

endpackage

// ===== rtl/acsr_mul.sv =====
// acsr_mul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on acsr_pkg.
module acsr_mul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [acsr_pkg::CHANNEL_BITS-1:0]  op_a,
	input  logic [acsr_pkg::CHANNEL_BITS-1:0]  op_b,
	output logic                               done,
	output logic [acsr_pkg::PROD_W-1:0]        product
);
	import acsr_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [PROD_W-1:0]       acc_q;
	logic [PROD_W-1:0]       mcand_q;
	logic [CHANNEL_BITS-1:0] mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= PROD_W'(op_a);
			mplier_q <= op_b;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== rtl/acsr_div.sv =====
// acsr_div: restoring divider, one quotient bit per cycle, quotient known to fit.
// Depends on acsr_pkg.
module acsr_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [acsr_pkg::NUM_W-1:0]         numer,
	input  logic [acsr_pkg::DEN_W-1:0]         denom,
	output logic                               done,
	output logic [acsr_pkg::CHANNEL_BITS-1:0]  quot
);
	import acsr_pkg::*;

	localparam int DSH_W = DEN_W + STEPS - 1;

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [NUM_W-1:0]        rem_q;
	logic [DSH_W-1:0]        dsh_q;
	logic [CHANNEL_BITS-1:0] quot_q;
	logic                    ge;

	// divisor is pre-shifted to the top quotient weight and walks down
	assign ge = rem_q >= NUM_W'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= numer;
			dsh_q  <= {denom, {(STEPS-1){1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - NUM_W'(dsh_q);
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[CHANNEL_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/alpha_contrast_stretch_recolor_core.sv =====
// Min-max contrast stretch with recolour. Pixels arrive as requests on the pixel
// channel; a measure request (cmd 0) folds the pixel's darkness into the running
// minimum and maximum and yields nothing, a recolour request (cmd 1) yields one
// result request carrying the tint colour and the stretched darkness as alpha.
// One pixel is in flight at a time: a measure pixel occupies the block through the
// bit-serial multiplier, one pass of the shared bit-serial divider and the fold into
// the range; a recolour pixel through the multiplier, up to two divider passes, the
// range checks and the load of the output register. A recolour pixel whose alpha is
// fixed by the range checks skips the second pass. The finished result sits in an output
// register, so the next pixel is taken while it waits; a new result is held back
// only if the previous one has still not been taken. Tint registers are written
// via the cfg channel, which is always ready. No memories, no clearing pass.
module alpha_contrast_stretch_recolor_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  acsr_pkg::pixel_t              pixel,
	output logic                          result_valid,
	input  logic                          result_stall,
	output acsr_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [acsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import acsr_pkg::*;

	state_t                  state_q;
	logic [7:0]              tint_red_q, tint_green_q, tint_blue_q;
	logic [CHANNEL_BITS-1:0] min_q, max_q;
	logic                    cmd_q, fs_q;
	logic [CHANNEL_BITS-1:0] v_q;
	logic [CHANNEL_BITS-1:0] alpha_q;
	logic                    res_vld_q;
	result_t                 res_q;

	logic                    accept;
	logic [CHANNEL_BITS-1:0] chan_max, inv_max;
	logic                    mul_done;
	logic [PROD_W-1:0]       prod;
	logic                    div_start, div_done;
	logic [NUM_W-1:0]        div_num;
	logic [DEN_W-1:0]        div_den;
	logic [CHANNEL_BITS-1:0] quot;
	logic [CHANNEL_BITS-1:0] rng, diff, base_min, base_max;
	logic [NUM_W-1:0]        str_num;
	logic                    empty_rng, below, above, res_load;

	assign accept      = pixel_valid && !pixel_stall;
	assign pixel_stall = (state_q != ST_IDLE);
	assign cfg_ready   = 1'b1;

	// darkness numerator: (M - max(r,g,b)) * alpha
	always_comb begin
		chan_max = pixel.pix_red;
		if (pixel.pix_green > chan_max)
			chan_max = pixel.pix_green;
		if (pixel.pix_blue > chan_max)
			chan_max = pixel.pix_blue;
		inv_max = CHAN_MAX - chan_max;
	end

	acsr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.op_a    (inv_max),
		.op_b    (pixel.pix_alpha),
		.done    (mul_done),
		.product (prod)
	);

	// stretch operands: q = (2*(v-min)*M + rng) / (2*rng); d*M = (d << N) - d
	assign rng       = max_q - min_q;
	assign diff      = v_q - min_q;
	assign str_num   = NUM_W'({({diff, {CHANNEL_BITS{1'b0}}} - PROD_W'(diff)), 1'b0})
	                 + NUM_W'(rng);
	assign empty_rng = (max_q <= min_q);
	assign below     = (v_q <= min_q);
	assign above     = (v_q >= max_q);

	// one divider, two uses: darkness rounding then stretch
	always_comb begin
		div_start = 1'b0;
		div_num   = str_num;
		div_den   = {rng, 1'b0};
		if (state_q == ST_MUL) begin
			div_start = mul_done;
			div_num   = NUM_W'(prod) + NUM_W'(CHAN_HALF);
			div_den   = DEN_W'(CHAN_MAX);
		end else if (state_q == ST_PREP) begin
			div_start = (cmd_q == CMD_RECOLOR) && !empty_rng && !below && !above;
		end
	end

	acsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_num),
		.denom  (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	assign base_min = fs_q ? CHAN_MAX : min_q;
	assign base_max = fs_q ? '0 : max_q;
	assign res_load = (state_q == ST_OUT) && (!res_vld_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_q   <= CHAN_MAX;
			max_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_done)
						state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_done)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (cmd_q == CMD_MEASURE) begin
						// frame start reopens the range before this pixel is folded in
						min_q   <= (v_q < base_min) ? v_q : base_min;
						max_q   <= (v_q > base_max) ? v_q : base_max;
						state_q <= ST_IDLE;
					end else if (div_start) begin
						state_q <= ST_DIV2;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV2: begin
					if (div_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= pixel.cmd;
			fs_q  <= pixel.frame_start;
		end
		if (state_q == ST_DIV1 && div_done)
			v_q <= quot;
		if (state_q == ST_PREP) begin
			// empty range or at/below min gives 0, at/above max saturates
			priority if (empty_rng || below)
				alpha_q <= '0;
			else if (above)
				alpha_q <= CHAN_MAX;
			else
				alpha_q <= alpha_q;
		end
		if (state_q == ST_DIV2 && div_done)
			alpha_q <= quot;
		if (res_load)
			res_q <= '{out_red: tint_red_q, out_green: tint_green_q,
			           out_blue: tint_blue_q, out_alpha: 8'(alpha_q)};
	end

	// output register: free once taken, refilled from the finishing pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_load) begin
			res_vld_q <= 1'b1;
		end else if (!result_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_red_q   <= '0;
			tint_green_q <= '0;
			tint_blue_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TINT_RED:   tint_red_q   <= cfg_data;
				REG_TINT_GREEN: tint_green_q <= cfg_data;
				REG_TINT_BLUE:  tint_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

// ===== rtl/acsr_chk.sv =====
// acsr_chk: port-level checks of the contrast stretch recolour block, bound to the top.
// Depends on acsr_pkg and alpha_contrast_stretch_recolor_core.
module acsr_chk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	input  logic              pixel_stall,
	input  acsr_pkg::pixel_t  pixel,
	input  logic              result_valid,
	input  logic              result_stall,
	input  acsr_pkg::result_t result
);
	import acsr_pkg::*;

	// stalled result request holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result request changed while stalled");

	// one pixel in flight: an accepted pixel blocks the next
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall |=> pixel_stall)
		else $error("pixel taken while another in flight");

	// a fresh result only comes out of a pixel in flight
	a_res_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(pixel_stall))
		else $error("result without a pixel in flight");

	// a measure pixel never finishes within the next cycle
	a_measure_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall && pixel.cmd == CMD_MEASURE |=> !$rose(result_valid))
		else $error("measure pixel produced a result");

endmodule

bind alpha_contrast_stretch_recolor_core acsr_chk u_acsr_chk (.*);

// ===== test/tb_alpha_contrast_stretch_recolor_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for alpha_contrast_stretch_recolor_core: measure and recolour frames,
// tint writes, random stalls on both sides. Depends on acsr_pkg and the core only.
module tb_alpha_contrast_stretch_recolor_core;
	import acsr_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 10;
	// settle time outlasts the worst pixel inside the block, so the block has gone idle
	localparam int SETTLE_CYCLES = 40;
	// the longest receiver hold-off is HOLD_CYCLES; anything far beyond that is a hang
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1250;
	// cfg index 3 maps to no register; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	logic pixel_valid;
	logic pixel_stall;
	pixel_t pixel;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;

	// predictor state: tint registers and the running darkness range
	logic [7:0] tint_r, tint_g, tint_b;
	logic [7:0] run_lo, run_hi;
	result_t recolour_due[$];

	// calm: no random idling on either side; hold_left: receiver hold-off countdown
	bit calm;
	int hold_left;
	int mismatches;
	int pixels_taken;
	int results_taken;
	int frames_run;
	int tint_writes;
	int quiet_cycles;
	result_t want;

	alpha_contrast_stretch_recolor_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// ---------------------------------------------------------------- predictor

	// darkness = round((M - max(r,g,b)) * alpha / M), half rounds up
	function automatic logic [7:0] darkness_of(pixel_t px);
		int peak;
		int prod;
		peak = px.pix_red;
		if (px.pix_green > peak) peak = px.pix_green;
		if (px.pix_blue > peak) peak = px.pix_blue;
		prod = (int'(CHAN_MAX) - peak) * int'(px.pix_alpha);
		return 8'((prod + int'(CHAN_MAX) / 2) / int'(CHAN_MAX));
	endfunction

	// stretch of v over lo..hi onto 0..M; empty range gives 0, outside saturates
	function automatic logic [7:0] stretched(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
		int num;
		int den;
		int q;
		if (hi <= lo) return 8'd0;
		if (v <= lo) return 8'd0;
		if (v >= hi) return CHAN_MAX;
		num = (int'(v) - int'(lo)) * int'(CHAN_MAX);
		den = int'(hi) - int'(lo);
		q = (2 * num + den) / (2 * den);
		if (q > int'(CHAN_MAX)) q = int'(CHAN_MAX);
		return 8'(q);
	endfunction

	// apply one accepted pixel request to the predicted state
	task automatic fold_pixel(input pixel_t px);
		logic [7:0] v;
		result_t r;
		v = darkness_of(px);
		if (px.cmd == CMD_MEASURE) begin
			// frame start only means something on a measure pixel
			if (px.frame_start) begin
				run_lo = CHAN_MAX;
				run_hi = 8'd0;
			end
			if (v < run_lo) run_lo = v;
			if (v > run_hi) run_hi = v;
		end else begin
			r.out_red = tint_r;
			r.out_green = tint_g;
			r.out_blue = tint_b;
			r.out_alpha = stretched(v, run_lo, run_hi);
			recolour_due.push_back(r);
		end
	endtask

	// ---------------------------------------------------------------- drivers

	function automatic pixel_t mk_pixel(logic cmd, logic fs, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] a);
		pixel_t px;
		px.cmd = cmd;
		px.frame_start = fs;
		px.pix_red = r;
		px.pix_green = g;
		px.pix_blue = b;
		px.pix_alpha = a;
		return px;
	endfunction

	// Entered and left at a falling edge. Valid is only lowered in the idle loop, so a
	// back-to-back request keeps valid high without a second assignment in one step.
	task automatic send_pixel(input pixel_t px);
		while (!calm && $urandom_range(99) < 20) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel <= px;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (pixel_stall);
		fold_pixel(px);
		pixels_taken++;
		@(negedge clk);
	endtask

	// stop offering, let every expected result arrive, then give the block time to
	// finish any measure pixel still in flight (those leave no trace in the queue)
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (recolour_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// cfg_valid is left high; the caller lowers it once the burst of writes is done
	task automatic write_tint(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TINT_RED: tint_r = val;
			REG_TINT_GREEN: tint_g = val;
			REG_TINT_BLUE: tint_b = val;
			default: ;
		endcase
		tint_writes++;
		@(negedge clk);
	endtask

	task automatic set_tints(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input bit poke_spare);
		wait_idle();
		write_tint(REG_TINT_RED, r);
		write_tint(REG_TINT_GREEN, g);
		write_tint(REG_TINT_BLUE, b);
		if (poke_spare) write_tint(REG_SPARE, 8'($urandom));
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// pixel whose peak channel is v_peak, others at or below it
	function automatic pixel_t peaked_pixel(logic cmd, logic fs, logic [7:0] v_peak,
			logic [7:0] a);
		pixel_t px;
		px = mk_pixel(cmd, fs, 8'($urandom_range(v_peak)), 8'($urandom_range(v_peak)),
			8'($urandom_range(v_peak)), a);
		case ($urandom_range(2))
			0: px.pix_red = v_peak;
			1: px.pix_green = v_peak;
			default: px.pix_blue = v_peak;
		endcase
		return px;
	endfunction

	// random content: fully random, narrow band around a base peak, or alpha extremes
	function automatic pixel_t random_pixel(int style, int base);
		pixel_t px;
		int p;
		px = pixel_t'({2'($urandom_range(3)), $urandom});
		case (style)
			1: begin
				p = base + $urandom_range(24) - 12;
				if (p < 0) p = 0;
				if (p > 255) p = 255;
				px = peaked_pixel(px.cmd, px.frame_start, 8'(p), CHAN_MAX);
			end
			2: begin
				case ($urandom_range(2))
					0: px.pix_alpha = 8'd0;
					1: px.pix_alpha = CHAN_MAX;
					default: ;
				endcase
			end
			default: ;
		endcase
		return px;
	endfunction

	function automatic logic [7:0] pick_tint();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return CHAN_MAX;
			default: return 8'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------- receiver and checks

	// receiver: a requested hold-off wins, otherwise no stall while calm, else a random stall at 20 percent odds
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (calm) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < 20);
		end
	end

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		mismatches++;
		$display("%0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
	endtask

	// every accepted result request is matched against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_taken++;
			if (recolour_due.size() == 0) begin
				report_mismatch("unexpected result, alpha", result.out_alpha, -1);
			end else begin
				want = recolour_due.pop_front();
				if (result.out_red !== want.out_red)
					report_mismatch("out_red", result.out_red, want.out_red);
				if (result.out_green !== want.out_green)
					report_mismatch("out_green", result.out_green, want.out_green);
				if (result.out_blue !== want.out_blue)
					report_mismatch("out_blue", result.out_blue, want.out_blue);
				if (result.out_alpha !== want.out_alpha)
					report_mismatch("out_alpha", result.out_alpha, want.out_alpha);
			end
		end
	end

	// watchdog: too long without any request moving on any channel
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles, %0d results outstanding", quiet_cycles,
				recolour_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// straight out of reset: tint is black and the range is empty, so alpha is 0;
	// frame start on a recolour pixel must be ignored
	task automatic test_reset_state();
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b1, 8'd0, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, CHAN_MAX, CHAN_MAX, CHAN_MAX, 8'd0));
	endtask

	// full range 0..255, then field extremes and each colour channel as the peak
	task automatic test_extremes();
		set_tints(CHAN_MAX, 8'd0, 8'h5a, 1'b1);
		send_pixel(mk_pixel(CMD_MEASURE, 1'b1, 8'd0, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_MEASURE, 1'b0, CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, 8'd0, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, 8'd128, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, 8'd0, 8'd200, 8'd0, 8'd128));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, 8'd0, 8'd0, 8'd55, CHAN_MAX));
	endtask

	// single-pixel (empty) range, pixels below and above the range, a half-way
	// rounding case, and a second frame start wiping the first
	task automatic test_range_cases();
		send_pixel(mk_pixel(CMD_MEASURE, 1'b1, 8'd155, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, 8'd155, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_MEASURE, 1'b0, 8'd0, 8'd105, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, CHAN_MAX, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, 8'd0, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, 8'd0, 8'd0, 8'd130, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b1, 8'd135, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, 8'd155, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_MEASURE, 1'b1, 8'd55, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_MEASURE, 1'b1, 8'd205, 8'd0, 8'd0, CHAN_MAX));
		send_pixel(mk_pixel(CMD_RECOLOR, 1'b0, 8'd205, 8'd0, 8'd0, CHAN_MAX));
	endtask

	// one frame: measure pass opened by frame start, then a recolour pass; some
	// frames are broken, with command and frame start random on every pixel
	task automatic run_frame();
		int n_meas;
		int n_rec;
		int style;
		int base;
		bit broken;
		pixel_t px;
		broken = ($urandom_range(99) < 15);
		n_meas = $urandom_range(1, 12);
		n_rec = $urandom_range(1, 12);
		style = $urandom_range(2);
		base = $urandom_range(255);
		for (int i = 0; i < n_meas + n_rec; i++) begin
			px = random_pixel(style, base);
			if (!broken) begin
				px.cmd = (i < n_meas) ? CMD_MEASURE : CMD_RECOLOR;
				px.frame_start = (i == 0);
			end
			send_pixel(px);
		end
		frames_run++;
	endtask

	// random frames, with tint changes now and then and one long calm stretch
	task automatic test_random_frames();
		int start_count;
		start_count = pixels_taken;
		set_tints(8'd0, 8'd0, 8'd0, 1'b0);
		while (pixels_taken - start_count < RANDOM_ITEMS) begin
			calm = (pixels_taken - start_count > 500) && (pixels_taken - start_count < 700);
			if ($urandom_range(7) == 0)
				set_tints(pick_tint(), pick_tint(), pick_tint(), $urandom_range(3) == 0);
			run_frame();
		end
		calm = 1'b0;
		set_tints(CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b1);
		run_frame();
	endtask

	// receiver holds off while the sender keeps offering recolour requests, so the
	// output register and the core fill and the input stalls; then a full drain
	task automatic test_backpressure();
		wait_idle();
		send_pixel(mk_pixel(CMD_MEASURE, 1'b1, 8'd10, 8'd20, 8'd30, CHAN_MAX));
		send_pixel(mk_pixel(CMD_MEASURE, 1'b0, 8'd240, 8'd20, 8'd30, CHAN_MAX));
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 8; i++)
			send_pixel(peaked_pixel(CMD_RECOLOR, 1'b0, 8'($urandom), 8'($urandom)));
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_left = 0;
		mismatches = 0;
		pixels_taken = 0;
		results_taken = 0;
		frames_run = 0;
		tint_writes = 0;
		quiet_cycles = 0;
		tint_r = 8'd0;
		tint_g = 8'd0;
		tint_b = 8'd0;
		run_lo = CHAN_MAX;
		run_hi = 8'd0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_extremes();
		test_range_cases();
		test_backpressure();
		test_random_frames();
		test_backpressure();

		wait_idle();
		$display("covered %0d pixel requests in %0d random frames, %0d recolour results,",
			pixels_taken, frames_run, results_taken);
		$display("%0d tint writes, result hold-offs and a calm stretch", tint_writes);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
